// ----- src/ctt_pkg.sv -----
// Package for the connection table block: payload structs, operation and
// result codes, register indexes and the compare unit interface types.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctt_pkg;

   // Operation codes of the request channel.
   localparam logic [1:0] OP_CONNECT    = 2'd0;
   localparam logic [1:0] OP_DISCONNECT = 2'd1;
   localparam logic [1:0] OP_ADVANCE    = 2'd2;

   // Result kinds of the response channel.
   localparam logic [2:0] KIND_CONNECTED = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_REMOVED   = 3'd2;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [2:0] KIND_EXPIRED   = 3'd4;
   localparam logic [2:0] KIND_NONE      = 3'd5;

   // Configuration register indexes.
   typedef logic [0:0] csr_idx_type;
   localparam csr_idx_type CSR_CAPACITY = 1'b0;
   localparam csr_idx_type CSR_TIMEOUT  = 1'b1;

   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] device_id;
      logic [31:0] tick_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] affected_id;
      logic [4:0]  entry_count;
      logic        last;
   } rsp_type;

   // One table entry as stored in the memory.
   typedef struct packed {
      logic [31:0] id;
      logic [31:0] stamp;
   } entry_type;

   // Operands of the shared compare unit.
   typedef struct packed {
      logic [31:0] opa;
      logic [31:0] opb;
      logic [31:0] opc;
   } alu_in_type;

   // Flags from the shared compare unit.
   typedef struct packed {
      logic eq;
      logic ge;
   } alu_out_type;

endpackage

`default_nettype wire

// ----- src/connection_table_with_timeout_core.sv -----
// Connection table with timeout. Connect: write the entry or report full, then emit.
// Disconnect: search by id; a hit at the last index is removed, else the last entry
// first moves into its slot. Advance: a read and check per scanned entry plus a search
// and move per expiry, all through one memory read port and one shared compare unit.
// One item at a time; the next request is taken when the sequencer is idle.
// Reset (synchronous) empties the table, zeroes time and loads register resets.
`default_nettype none

module connection_table_with_timeout_core
   import ctt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CONN     = 4'd1;
   localparam logic [3:0] S_SRCH     = 4'd2;
   localparam logic [3:0] S_MV_RD    = 4'd3;
   localparam logic [3:0] S_MV_WR    = 4'd4;
   localparam logic [3:0] S_RMV      = 4'd5;
   localparam logic [3:0] S_SCAN_RD  = 4'd6;
   localparam logic [3:0] S_SCAN_CHK = 4'd7;
   localparam logic [3:0] S_SCAN_END = 4'd8;
   localparam logic [3:0] S_EMIT     = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [3:0]       ret_ff, ret_in;
   logic [1:0]       mode_ff, mode_in;
   logic [31:0]      key_ff, key_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [31:0]      now_ff, now_in;
   logic [4:0]       cap_ff, cap_in;
   logic [31:0]      timeout_ff, timeout_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] ix_ff, ix_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [2:0]       hold_kind_ff, hold_kind_in;
   logic [31:0]      hold_id_ff, hold_id_in;
   logic [CNT_W-1:0] hold_cnt_ff, hold_cnt_in;
   logic             emit_last_ff, emit_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;
   alu_in_type       alu_in;
   alu_out_type      alu_out;

   logic [CNT_W-1:0] live_m1;
   logic             issue;
   logic             full;

   ctt_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ctt_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   // Helpers shared by several states.
   always_comb begin
      live_m1 = live_ff - CNT_W'(1);
      issue   = (scan_ff < live_ff);
      full    = (32'(live_ff) >= 32'(cap_ff)) || (32'(live_ff) >= TABLE_DEPTH);
   end

   // Compare unit operands: age check in the scan, id match otherwise.
   always_comb begin
      if (state_ff == S_SCAN_CHK) begin
         alu_in.opa = now_ff;
         alu_in.opc = timeout_ff;
      end else begin
         alu_in.opa = mem_rd_data.id;
         alu_in.opc = key_ff;
      end
      alu_in.opb = mem_rd_data.stamp;
   end

   // Read address selection.
   always_comb begin
      unique case (state_ff)
         S_MV_RD:   mem_rd_addr = live_m1[IDX_W-1:0];
         S_SCAN_RD: mem_rd_addr = ix_ff;
         default:   mem_rd_addr = scan_ff[IDX_W-1:0];
      endcase
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cap_in     = cap_ff;
      timeout_in = timeout_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_in     = csr_wdata[4:0];
            CSR_TIMEOUT:  timeout_in = csr_wdata;
            default:      cap_in     = cap_ff;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      live_in       = live_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      j_in          = j_ff;
      ix_in         = ix_ff;
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_id_in    = hold_id_ff;
      hold_cnt_in   = hold_cnt_ff;
      emit_last_in  = emit_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = j_ff;
      mem_wr_data   = mem_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in       = req_data.op;
               key_in        = req_data.device_id;
               hold_valid_in = 1'b0;
               scan_in       = '0;
               pend_in       = 1'b0;
               unique case (req_data.op)
                  OP_CONNECT:    state_in = S_CONN;
                  OP_DISCONNECT: state_in = S_SRCH;
                  OP_ADVANCE: begin
                     now_in = now_ff + req_data.tick_count;
                     ix_in  = live_m1[IDX_W-1:0];
                     if (live_ff == '0) begin
                        state_in = S_SCAN_END;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  default:       state_in = S_IDLE;
               endcase
            end
         end

         S_CONN: begin
            hold_id_in   = key_ff;
            emit_last_in = 1'b1;
            ret_in       = S_IDLE;
            state_in     = S_EMIT;
            if (full) begin
               hold_kind_in = KIND_FULL;
               hold_cnt_in  = live_ff;
            end else begin
               mem_wr_en         = 1'b1;
               mem_wr_addr       = live_ff[IDX_W-1:0];
               mem_wr_data.id    = key_ff;
               mem_wr_data.stamp = now_ff;
               live_in           = live_ff + CNT_W'(1);
               hold_kind_in      = KIND_CONNECTED;
               hold_cnt_in       = live_ff + CNT_W'(1);
            end
         end

         // One read issued per cycle; the entry read in the previous cycle is checked.
         S_SRCH: begin
            pend_in     = issue;
            pend_idx_in = scan_ff[IDX_W-1:0];
            scan_in     = issue ? scan_ff + CNT_W'(1) : scan_ff;
            if (pend_ff && alu_out.eq) begin
               j_in    = pend_idx_ff;
               pend_in = 1'b0;
               if (pend_idx_ff == live_m1[IDX_W-1:0]) begin
                  state_in = S_RMV;
               end else begin
                  state_in = S_MV_RD;
               end
            end else if (!pend_ff && !issue) begin
               if (mode_ff == OP_DISCONNECT) begin
                  hold_kind_in = KIND_NOT_FOUND;
                  hold_id_in   = key_ff;
                  hold_cnt_in  = live_ff;
                  emit_last_in = 1'b1;
                  ret_in       = S_IDLE;
                  state_in     = S_EMIT;
               end else if (ix_ff == '0) begin
                  state_in = S_SCAN_END;
               end else begin
                  ix_in    = ix_ff - IDX_W'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end

         S_MV_RD: begin
            state_in = S_MV_WR;
         end

         // The last entry moves into the freed slot.
         S_MV_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff;
            mem_wr_data = mem_rd_data;
            state_in    = S_RMV;
         end

         S_RMV: begin
            live_in     = live_m1;
            hold_id_in  = key_ff;
            hold_cnt_in = live_m1;
            if (mode_ff == OP_DISCONNECT) begin
               hold_kind_in = KIND_REMOVED;
               emit_last_in = 1'b1;
               ret_in       = S_IDLE;
               state_in     = S_EMIT;
            end else begin
               hold_kind_in  = KIND_EXPIRED;
               hold_valid_in = 1'b1;
               if (ix_ff == '0) begin
                  state_in = S_SCAN_END;
               end else begin
                  ix_in    = ix_ff - IDX_W'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end

         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end

         // An expired entry is removed by id; a held expiry goes out first.
         S_SCAN_CHK: begin
            if (alu_out.ge) begin
               key_in  = mem_rd_data.id;
               scan_in = '0;
               pend_in = 1'b0;
               if (hold_valid_ff) begin
                  emit_last_in = 1'b0;
                  ret_in       = S_SRCH;
                  state_in     = S_EMIT;
               end else begin
                  state_in = S_SRCH;
               end
            end else if (ix_ff == '0) begin
               state_in = S_SCAN_END;
            end else begin
               ix_in    = ix_ff - IDX_W'(1);
               state_in = S_SCAN_RD;
            end
         end

         S_SCAN_END: begin
            if (!hold_valid_ff) begin
               hold_kind_in = KIND_NONE;
               hold_id_in   = '0;
               hold_cnt_in  = live_ff;
            end
            emit_last_in = 1'b1;
            ret_in       = S_IDLE;
            state_in     = S_EMIT;
         end

         // Load the output register once it is free.
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = hold_kind_ff;
               rsp_data_in.affected_id = hold_id_ff;
               rsp_data_in.entry_count = 5'(hold_cnt_ff);
               rsp_data_in.last        = emit_last_ff;
               hold_valid_in           = 1'b0;
               state_in                = ret_ff;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         now_ff        <= '0;
         cap_ff        <= CAPACITY_RESET;
         timeout_ff    <= '0;
         pend_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         now_ff        <= now_in;
         cap_ff        <= cap_in;
         timeout_ff    <= timeout_in;
         pend_ff       <= pend_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      scan_ff      <= scan_in;
      pend_idx_ff  <= pend_idx_in;
      j_ff         <= j_in;
      ix_ff        <= ix_in;
      hold_kind_ff <= hold_kind_in;
      hold_id_ff   <= hold_id_in;
      hold_cnt_ff  <= hold_cnt_in;
      emit_last_ff <= emit_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The table never holds more entries than it has slots.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      32'(live_ff) <= TABLE_DEPTH)
      else $error("live count exceeds table depth");

   // A removal only happens on a non-empty table and takes exactly one entry.
   a_rmv_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMV) |-> (live_ff != '0))
      else $error("removal on empty table");

   a_rmv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMV) |=> (live_ff == $past(live_ff) - CNT_W'(1)))
      else $error("removal did not drop the count by one");

   // The search pointer never runs past the live entries.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (scan_ff <= live_ff))
      else $error("search pointer beyond live entries");

   // A successful connect always reports a non-empty table.
   a_conn_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.result_kind == KIND_CONNECTED))
      |-> (rsp_data_ff.entry_count != 5'd0))
      else $error("connect result with zero entries");
`endif

endmodule

`default_nettype wire

// ----- src/ctt_table.sv -----
// Entry memory of the connection table: one write port and one read port
// with registered read data. Depends on ctt_pkg for the entry type.
`default_nettype none

module ctt_table
   import ctt_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, read every cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/ctt_alu.sv -----
// Shared compare unit: id equality for searches and wrapped age against
// the timeout for the expiry scan. Depends on ctt_pkg for its structs.
`default_nettype none

module ctt_alu
   import ctt_pkg::*;
(
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   logic [31:0] age;

   // Age with unsigned wrap, then one compare against the threshold.
   always_comb begin
      age        = alu_in.opa - alu_in.opb;
      alu_out.ge = (age >= alu_in.opc);
      alu_out.eq = (alu_in.opa == alu_in.opc);
   end

endmodule

`default_nettype wire

// ----- test/connection_table_with_timeout_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for connection_table_with_timeout_core: a directed table
// of requests and register writes, then random phases, all checked by a local predictor.
// Depends on ctt_pkg and the core module only.

module connection_table_with_timeout_core_tb;
   import ctt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Quiet cycles before a register write, after the last result has arrived.
   localparam int SETTLE_CYCLES = 24;
   // Cycles allowed after the final result; covers a full expiry scan.
   localparam int TAIL_CYCLES = 400;
   localparam int PHASE_ITEMS = 36;
   localparam int PHASE_COUNT = 8;
   localparam int MAX_PRINTED = 40;

   // Block ports; the inputs are known from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_CAPACITY;
   logic [31:0] csr_wdata = '0;

   // Predicted table contents, time and register copies.
   logic [31:0] slot_id [TABLE_DEPTH];
   logic [31:0] slot_stamp [TABLE_DEPTH];
   int          live_slots = 0;
   logic [31:0] now_ticks = '0;
   logic [4:0]  capacity_setting = CAPACITY_RESET;
   logic [31:0] timeout_setting = '0;

   // Results still owed by the block, oldest first.
   rsp_type     awaited[$];
   int          error_count = 0;
   bit          quiet_end = 1'b0;
   logic [31:0] id_pool [6];

   // Receiver stall state.
   int          stall_left = 0;
   logic [31:0] sink_cycle = '0;

   // One row of the directed table: a register write or a request.
   typedef struct {
      bit          is_write;
      csr_idx_type reg_index;
      logic [31:0] reg_value;
      req_type     item;
      bit          has_answer;
      rsp_type     answer;
   } plan_row_type;

   plan_row_type directed_plan[$];

   connection_table_with_timeout_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Hard limit on the run, far beyond the slowest legal schedule.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED) begin
         $display("%0t: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic void post_result(input logic [2:0] kind, input logic [31:0] id,
                                       input logic last_flag);
      rsp_type entry;
      entry.result_kind = kind;
      entry.affected_id = id;
      entry.entry_count = 5'(live_slots);
      entry.last        = last_flag;
      awaited.push_back(entry);
   endfunction

   // Drop the lowest slot holding this id; the top slot moves into its place.
   function automatic bit evict_first(input logic [31:0] id);
      for (int i = 0; i < live_slots; i++) begin
         if (slot_id[i] == id) begin
            slot_id[i]    = slot_id[live_slots - 1];
            slot_stamp[i] = slot_stamp[live_slots - 1];
            live_slots--;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Update the predicted table for one accepted request and queue its results.
   function automatic void predict_outcome(input req_type item);
      int          limit;
      int          expired;
      logic [31:0] age;
      logic [31:0] victim;
      rsp_type     held;
      limit = (capacity_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_setting);
      held  = '0;
      case (item.op)
         OP_CONNECT: begin
            if (live_slots >= limit) begin
               post_result(KIND_FULL, item.device_id, 1'b1);
            end else begin
               slot_id[live_slots]    = item.device_id;
               slot_stamp[live_slots] = now_ticks;
               live_slots++;
               post_result(KIND_CONNECTED, item.device_id, 1'b1);
            end
         end
         OP_DISCONNECT: begin
            if (evict_first(item.device_id)) begin
               post_result(KIND_REMOVED, item.device_id, 1'b1);
            end else begin
               post_result(KIND_NOT_FOUND, item.device_id, 1'b1);
            end
         end
         OP_ADVANCE: begin
            now_ticks = now_ticks + item.tick_count;
            expired   = 0;
            // Scan from the top slot down; an expiry evicts by id, which may hit a lower slot.
            for (int ix = live_slots - 1; ix >= 0; ix--) begin
               if (ix < live_slots) begin
                  age = now_ticks - slot_stamp[ix];
                  if (age >= timeout_setting) begin
                     victim = slot_id[ix];
                     void'(evict_first(victim));
                     if (expired > 0) begin
                        awaited.push_back(held);
                     end
                     held.result_kind = KIND_EXPIRED;
                     held.affected_id = victim;
                     held.entry_count = 5'(live_slots);
                     held.last        = 1'b0;
                     expired++;
                  end
               end
            end
            if (expired == 0) begin
               post_result(KIND_NONE, '0, 1'b1);
            end else begin
               held.last = 1'b1;
               awaited.push_back(held);
            end
         end
         default: begin
            // The unused operation leaves everything as it is.
         end
      endcase
   endfunction

   // Compare one result transfer with the oldest prediction.
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited.size() == 0) begin
         report_mismatch($sformatf("result kind %0d id %h with nothing pending",
                                   got.result_kind, got.affected_id));
      end else begin
         want = awaited.pop_front();
         if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %0d, wanted %0d",
                                      got.result_kind, want.result_kind));
         if (got.affected_id !== want.affected_id)
            report_mismatch($sformatf("affected_id %h, wanted %h",
                                      got.affected_id, want.affected_id));
         if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                      got.entry_count, want.entry_count));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
      end
   endtask

   // Result channel monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_result(rsp_data);
      end
   end

   // Receiver stall bursts start only while bit 6 of the sink cycle counter is set.
   always @(posedge clock) begin
      sink_cycle <= sink_cycle + 1;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if (!quiet_end && sink_cycle[6] && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 12);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one request and hold it until the transfer; valid stays high afterward.
   task automatic send_request(input req_type item, input bit allow_gap);
      if (allow_gap && !quiet_end && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_outcome(item);
   endtask

   // Stop sending and wait until every predicted result has been seen.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the caller lowers csr_valid after its last write.
   task automatic write_register(input csr_idx_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CAPACITY) begin
         capacity_setting = value[4:0];
      end else begin
         timeout_setting = value;
      end
   endtask

   task automatic apply_settings(input logic [4:0] capacity, input logic [31:0] timeout);
      drain_results();
      write_register(CSR_CAPACITY, {27'd0, capacity});
      write_register(CSR_TIMEOUT, timeout);
      csr_valid <= 1'b0;
   endtask

   function automatic void plan_item(input logic [1:0] op, input logic [31:0] id,
                                     input logic [31:0] ticks);
      plan_row_type row;
      row.is_write   = 1'b0;
      row.reg_index  = CSR_CAPACITY;
      row.reg_value  = '0;
      row.item       = {op, id, ticks};
      row.has_answer = 1'b0;
      row.answer     = '0;
      directed_plan.push_back(row);
   endfunction

   // A request whose single result is known in advance.
   function automatic void plan_known(input logic [1:0] op, input logic [31:0] id,
                                      input logic [31:0] ticks, input logic [2:0] kind,
                                      input logic [31:0] affected, input logic [4:0] count);
      plan_row_type row;
      row.is_write   = 1'b0;
      row.reg_index  = CSR_CAPACITY;
      row.reg_value  = '0;
      row.item       = {op, id, ticks};
      row.has_answer = 1'b1;
      row.answer     = {kind, affected, count, 1'b1};
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_write(input csr_idx_type idx, input logic [31:0] value);
      plan_row_type row;
      row.is_write   = 1'b1;
      row.reg_index  = idx;
      row.reg_value  = value;
      row.item       = '0;
      row.has_answer = 1'b0;
      row.answer     = '0;
      directed_plan.push_back(row);
   endfunction

   // Mostly ids from a small pool, so duplicates and repeat hits are common.
   function automatic logic [31:0] pooled_id();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return id_pool[$urandom_range(0, 5)];
   endfunction

   function automatic req_type random_request(input int connect_pct, input bit wide_ticks);
      req_type item;
      int      roll;
      roll            = $urandom_range(0, 99);
      item.device_id  = $urandom;
      item.tick_count = $urandom;
      if (roll < 4) begin
         item.op = OP_UNUSED;
      end else if (roll < 4 + connect_pct) begin
         item.op        = OP_CONNECT;
         item.device_id = pooled_id();
      end else if (roll < 4 + connect_pct + (96 - connect_pct) * 6 / 10) begin
         item.op = OP_DISCONNECT;
         if (live_slots > 0 && $urandom_range(0, 9) < 7) begin
            item.device_id = slot_id[$urandom_range(0, live_slots - 1)];
         end else begin
            item.device_id = pooled_id();
         end
      end else begin
         item.op = OP_ADVANCE;
         if (!wide_ticks && $urandom_range(0, 7) != 0) begin
            item.tick_count = $urandom_range(0, 6);
         end
      end
      return item;
   endfunction

   initial begin
      req_type     item;
      logic [4:0]  capacity;
      logic [31:0] timeout;
      int          connect_pct;
      bit          wide_ticks;
      int          counted;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Reset settings: capacity 16, timeout 0.
      plan_known(OP_DISCONNECT, 32'h0, 32'h0, KIND_NOT_FOUND, 32'h0, 5'd0);
      plan_known(OP_ADVANCE, 32'h0, 32'h0, KIND_NONE, 32'h0, 5'd0);
      plan_known(OP_CONNECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_CONNECTED, 32'hFFFF_FFFF, 5'd1);
      plan_known(OP_CONNECT, 32'h0, 32'h0, KIND_CONNECTED, 32'h0, 5'd2);
      plan_known(OP_CONNECT, 32'hFFFF_FFFF, 32'h0, KIND_CONNECTED, 32'hFFFF_FFFF, 5'd3);
      plan_item(OP_UNUSED, 32'h1234_5678, 32'hFFFF_FFFF);
      // Zero timeout expires every entry, with a duplicate id in the table.
      plan_item(OP_ADVANCE, 32'h0, 32'h0);
      plan_write(CSR_CAPACITY, 32'd2);
      plan_write(CSR_TIMEOUT, 32'hFFFF_FFFF);
      plan_known(OP_CONNECT, 32'd1, 32'h0, KIND_CONNECTED, 32'd1, 5'd1);
      plan_known(OP_CONNECT, 32'd2, 32'h0, KIND_CONNECTED, 32'd2, 5'd2);
      plan_known(OP_CONNECT, 32'd3, 32'h0, KIND_FULL, 32'd3, 5'd2);
      plan_known(OP_DISCONNECT, 32'd1, 32'h0, KIND_REMOVED, 32'd1, 5'd1);
      plan_known(OP_CONNECT, 32'd4, 32'h0, KIND_CONNECTED, 32'd4, 5'd2);
      plan_known(OP_ADVANCE, 32'h0, 32'hFFFF_FFFE, KIND_NONE, 32'h0, 5'd2);
      plan_item(OP_ADVANCE, 32'h0, 32'd1);
      plan_write(CSR_CAPACITY, 32'd0);
      plan_known(OP_CONNECT, 32'hA5A5_A5A5, 32'h0, KIND_FULL, 32'hA5A5_A5A5, 5'd0);
      // Capacity above the table depth, and expiry across a wrap of the time.
      plan_write(CSR_CAPACITY, 32'd31);
      plan_write(CSR_TIMEOUT, 32'd3);
      plan_item(OP_CONNECT, 32'd10, 32'h0);
      plan_item(OP_ADVANCE, 32'h0, 32'd2);
      plan_item(OP_CONNECT, 32'd11, 32'h0);
      plan_item(OP_ADVANCE, 32'h0, 32'd1);
      plan_known(OP_DISCONNECT, 32'd11, 32'h0, KIND_REMOVED, 32'd11, 5'd0);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write) begin
            drain_results();
            write_register(directed_plan[i].reg_index, directed_plan[i].reg_value);
            csr_valid <= 1'b0;
         end else begin
            send_request(directed_plan[i].item, 1'b1);
            if (directed_plan[i].has_answer) begin
               void'(awaited.pop_back());
               awaited.push_back(directed_plan[i].answer);
            end
         end
      end

      // Random phases, each with its own register settings and operation mix.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wide_ticks = 1'b0;
         case (phase)
            0: begin capacity = 5'd31; timeout = 32'hFFFF_FFFF; connect_pct = 70; end
            1: begin capacity = 5'd16; timeout = 32'h0; connect_pct = 55; end
            2: begin
               capacity    = 5'($urandom_range(1, 15));
               timeout     = $urandom_range(5, 40);
               connect_pct = 50;
            end
            3: begin capacity = 5'd16; timeout = $urandom; connect_pct = 50; wide_ticks = 1'b1; end
            4: begin
               capacity    = 5'($urandom_range(0, 16));
               timeout     = $urandom_range(1, 12);
               connect_pct = 45;
            end
            5: begin
               capacity    = 5'($urandom_range(17, 31));
               timeout     = $urandom_range(1, 10);
               connect_pct = 60;
            end
            6: begin capacity = 5'd16; timeout = 32'd20; connect_pct = 50; end
            default: begin capacity = 5'd16; timeout = 32'd8; connect_pct = 50; end
         endcase
         apply_settings(capacity, timeout);
         quiet_end = (phase == PHASE_COUNT - 1);
         foreach (id_pool[k]) id_pool[k] = $urandom;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            item = random_request(connect_pct, wide_ticks);
            if (item.op != OP_UNUSED) counted++;
            // Now and then the sender waits for the block to go fully quiet.
            if (!quiet_end && $urandom_range(0, 29) == 0) drain_results();
            send_request(item, (counted % 32) < 22);
         end
      end

      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
